/* hw/rtl/lcal_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcal_pkg: shared definitions for the lowest common ancestor lifting unit.
// Holds field widths, the datapath micro-operations, jump conditions, the
// control and status structs and the microcode program itself.
// ----------------------------------------------------------------------------
package lcal_pkg;

   // Widths fixed by the item fields.
   localparam int NODE_FIELD_W = 10;
   localparam int DEPTH_W      = 11;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

   // Defaults for the top level parameters.
   localparam int MAX_NODES_DEFAULT = 1024;
   localparam int LEVELS_DEFAULT    = 10;

   // Step counter of the sequencer.
   localparam int STEP_W = 4;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_CLEAR      = 4'd0;
   localparam step_type STEP_IDLE       = 4'd1;
   localparam step_type STEP_DISPATCH   = 4'd2;
   localparam step_type STEP_ADD_CHK    = 4'd3;
   localparam step_type STEP_ADD_ROOT   = 4'd4;
   localparam step_type STEP_ADD_RD     = 4'd5;
   localparam step_type STEP_ADD_WR     = 4'd6;
   localparam step_type STEP_Q_ORDER    = 4'd7;
   localparam step_type STEP_Q_LIFT_RD  = 4'd8;
   localparam step_type STEP_Q_LIFT     = 4'd9;
   localparam step_type STEP_Q_EQ       = 4'd10;
   localparam step_type STEP_Q_CLIMB    = 4'd11;
   localparam step_type STEP_Q_EMIT_ANC = 4'd12;
   localparam step_type STEP_Q_EMIT_X   = 4'd13;

   // Datapath micro-operations.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_CLEAR,
      OP_ACCEPT,
      OP_ADD_ROOT,
      OP_ADD_FILL,
      OP_ORDER,
      OP_LIFT_RD,
      OP_LIFT,
      OP_CLIMB,
      OP_EMIT_ANC,
      OP_EMIT_X
   } op_type;

   // Jump conditions. When the condition holds the sequencer jumps to the
   // target step, otherwise it falls through to the next step.
   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_CLR_MORE,
      C_NO_REQ,
      C_QUERY,
      C_NODE_ZERO,
      C_LVL_TOP,
      C_LVL_NZ,
      C_EQ
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } uword_type;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      op_type op;
      logic   load;
   } ctl_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic is_query;
      logic node_zero;
      logic lvl_top;
      logic lvl_nz;
      logic nodes_eq;
      logic clr_more;
      logic out_busy;
   } status_type;

   // Microcode program.
   function automatic uword_type ucode(input step_type step);
      uword_type w;
      unique case (step)
         STEP_CLEAR:      w = '{OP_CLEAR,    C_CLR_MORE,  STEP_CLEAR};
         STEP_IDLE:       w = '{OP_ACCEPT,   C_NO_REQ,    STEP_IDLE};
         STEP_DISPATCH:   w = '{OP_NOP,      C_QUERY,     STEP_Q_ORDER};
         STEP_ADD_CHK:    w = '{OP_NOP,      C_NODE_ZERO, STEP_IDLE};
         STEP_ADD_ROOT:   w = '{OP_ADD_ROOT, C_NEVER,     STEP_IDLE};
         STEP_ADD_RD:     w = '{OP_NOP,      C_LVL_TOP,   STEP_IDLE};
         STEP_ADD_WR:     w = '{OP_ADD_FILL, C_ALWAYS,    STEP_ADD_RD};
         STEP_Q_ORDER:    w = '{OP_ORDER,    C_NEVER,     STEP_IDLE};
         STEP_Q_LIFT_RD:  w = '{OP_LIFT_RD,  C_NEVER,     STEP_IDLE};
         STEP_Q_LIFT:     w = '{OP_LIFT,     C_LVL_NZ,    STEP_Q_LIFT_RD};
         STEP_Q_EQ:       w = '{OP_NOP,      C_EQ,        STEP_Q_EMIT_X};
         STEP_Q_CLIMB:    w = '{OP_CLIMB,    C_LVL_NZ,    STEP_Q_CLIMB};
         STEP_Q_EMIT_ANC: w = '{OP_EMIT_ANC, C_ALWAYS,    STEP_IDLE};
         STEP_Q_EMIT_X:   w = '{OP_EMIT_X,   C_ALWAYS,    STEP_IDLE};
         default:         w = '{OP_NOP,      C_ALWAYS,    STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

/* hw/rtl/lcal_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcal_sequencer: microcode sequencer.
// Reads one control word per step from the program table, evaluates its
// jump condition against datapath status and steps or jumps.
// ----------------------------------------------------------------------------
module lcal_sequencer
   import lcal_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type status,
   output ctl_type    ctl,
   output logic       req_ready
);

   step_type  step_ff;
   step_type  step_in;
   uword_type word;
   logic      take;
   logic      stall;

   // Fetch the control word for the current step.
   always_comb begin
      word = ucode(step_ff);
   end

   // Evaluate the jump condition.
   always_comb begin
      unique case (word.cond)
         C_NEVER:     take = 1'b0;
         C_ALWAYS:    take = 1'b1;
         C_CLR_MORE:  take = status.clr_more;
         C_NO_REQ:    take = !req_valid;
         C_QUERY:     take = status.is_query;
         C_NODE_ZERO: take = status.node_zero;
         C_LVL_TOP:   take = status.lvl_top;
         C_LVL_NZ:    take = status.lvl_nz;
         C_EQ:        take = status.nodes_eq;
         default:     take = 1'b0;
      endcase
   end

   // A result step waits while the output register still holds a result.
   assign stall = ((word.op == OP_EMIT_ANC) || (word.op == OP_EMIT_X)) && status.out_busy;

   always_comb begin
      priority if (stall) begin
         step_in = step_ff;
      end else if (take) begin
         step_in = word.target;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

   // Handshake and control to the datapath.
   assign req_ready = (word.op == OP_ACCEPT);
   assign ctl.op    = word.op;
   assign ctl.load  = req_ready && req_valid;

   // Once the clearing pass is over it never comes back.
   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      (step_ff != STEP_CLEAR) |=> (step_ff != STEP_CLEAR))
      else $error("sequencer returned to the clearing pass");

   // Every accepted transfer is dispatched in the next cycle.
   a_dispatch: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> (step_ff == STEP_DISPATCH))
      else $error("accepted transfer was not dispatched");

   // A delivered result ends the item.
   a_emit_end: assert property (@(posedge clock) disable iff (reset)
      ((word.op == OP_EMIT_ANC) || (word.op == OP_EMIT_X)) && !stall
      |=> (step_ff == STEP_IDLE))
      else $error("result step did not return to idle");

endmodule

/* hw/rtl/lcal_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcal_datapath: working registers, ancestor table and depth store.
// Executes one micro-operation per cycle, owns the clearing sweep and the
// result register, and reports status to the sequencer.
// ----------------------------------------------------------------------------
module lcal_datapath
   import lcal_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEFAULT,
   parameter int LEVELS    = LEVELS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ctl_type                      ctl,
   input  logic                         req_type,
   input  logic [$clog2(MAX_NODES)-1:0] req_node_a,
   input  logic [$clog2(MAX_NODES)-1:0] req_node_b,
   input  logic                         rsp_ready,
   output status_type                   status,
   output logic                         rsp_valid,
   output logic [NODE_FIELD_W-1:0]      rsp_ancestor
);

   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int LVL_W     = $clog2(LEVELS + 1);
   localparam int TBL_DEPTH = MAX_NODES * (2 ** LVL_W);
   localparam int CLR_W     = NODE_W + LVL_W;
   localparam int EXT_W     = (NODE_W > NODE_FIELD_W) ? NODE_W : NODE_FIELD_W;
   localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(TBL_DEPTH - 1);
   localparam logic [LVL_W-1:0] LVL_TOP  = LVL_W'(LEVELS);

   // Ancestor table: address is {node, level}. Depth store: one per node.
   logic [NODE_W-1:0]  anc_mem   [TBL_DEPTH];
   logic [DEPTH_W-1:0] depth_mem [MAX_NODES];

   logic                    type_ff, type_in;
   logic [NODE_W-1:0]       x_ff, x_in;
   logic [NODE_W-1:0]       y_ff, y_in;
   logic [NODE_W-1:0]       up_ff, up_in;
   logic [LVL_W-1:0]        lvl_ff, lvl_in;
   logic [DEPTH_W-1:0]      dy_ff, dy_in;
   logic [CLR_W-1:0]        clr_ff, clr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [NODE_FIELD_W-1:0] rsp_ancestor_ff, rsp_ancestor_in;
   logic [NODE_W-1:0]       anc_rd0_ff, anc_rd1_ff;
   logic [DEPTH_W-1:0]      depth_rd0_ff, depth_rd1_ff;

   logic                    lt, ge, ne, lvl_nz, out_busy, emit;
   logic [LVL_W-1:0]        lvl_dec, lvl_inc;
   logic                    anc_we, depth_we;
   logic [CLR_W-1:0]        anc_waddr;
   logic [NODE_W-1:0]       anc_wdata;
   logic [NODE_W-1:0]       depth_waddr, depth_raddr0;
   logic [DEPTH_W-1:0]      depth_wdata;
   logic [NODE_W-1:0]       emit_node;
   logic [EXT_W-1:0]        emit_ext;

   // Comparisons on the registered read data.
   assign lt      = depth_rd0_ff < depth_rd1_ff;
   assign ge      = depth_rd0_ff >= dy_ff;
   assign ne      = anc_rd0_ff != anc_rd1_ff;
   assign lvl_nz  = lvl_ff != '0;
   assign lvl_dec = lvl_ff - 1'b1;
   assign lvl_inc = lvl_ff + 1'b1;

   assign out_busy = rsp_valid_ff && !rsp_ready;
   assign emit     = ((ctl.op == OP_EMIT_ANC) || (ctl.op == OP_EMIT_X)) && !out_busy;

   // Next values of the working registers.
   always_comb begin
      type_in = type_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      up_in   = up_ff;
      lvl_in  = lvl_ff;
      dy_in   = dy_ff;
      clr_in  = clr_ff;
      unique case (ctl.op)
         OP_CLEAR: begin
            clr_in = clr_ff + 1'b1;
         end
         OP_ACCEPT: begin
            if (ctl.load) begin
               type_in = req_type;
               x_in    = req_node_a;
               y_in    = req_node_b;
               lvl_in  = '0;
            end
         end
         OP_ADD_FILL: begin
            y_in   = anc_rd1_ff;
            lvl_in = lvl_inc;
         end
         OP_ORDER: begin
            // Put the deeper node in x and keep the depth of the other.
            if (lt) begin
               x_in = y_ff;
               y_in = x_ff;
            end
            dy_in  = lt ? depth_rd0_ff : depth_rd1_ff;
            lvl_in = LVL_TOP;
         end
         OP_LIFT_RD: begin
            up_in = anc_rd0_ff;
         end
         OP_LIFT: begin
            if (ge) begin
               x_in = up_ff;
            end
            lvl_in = lvl_nz ? lvl_dec : LVL_TOP;
         end
         OP_CLIMB: begin
            if (ne) begin
               x_in = anc_rd0_ff;
               y_in = anc_rd1_ff;
            end
            lvl_in = lvl_nz ? lvl_dec : '0;
         end
         default: begin
         end
      endcase
   end

   // Table write port: clearing sweep, level zero of a new row, or fill.
   assign anc_we    = (ctl.op == OP_CLEAR) || (ctl.op == OP_ADD_ROOT) ||
                      (ctl.op == OP_ADD_FILL);
   assign anc_waddr = (ctl.op == OP_CLEAR) ? clr_ff : {x_ff, lvl_in};
   assign anc_wdata = (ctl.op == OP_CLEAR)    ? '0   :
                      (ctl.op == OP_ADD_ROOT) ? y_ff : anc_rd1_ff;

   // Depth write port: clearing sweep or the new node's saturated depth.
   assign depth_we    = (ctl.op == OP_CLEAR) || (ctl.op == OP_ADD_ROOT);
   assign depth_waddr = (ctl.op == OP_CLEAR) ? clr_ff[CLR_W-1:LVL_W] : x_ff;
   assign depth_wdata = (ctl.op == OP_CLEAR)        ? '0        :
                        (depth_rd1_ff == DEPTH_MAX) ? DEPTH_MAX : depth_rd1_ff + 1'b1;

   // While lifting, the depth looked up is that of the candidate ancestor.
   assign depth_raddr0 = (ctl.op == OP_LIFT_RD) ? anc_rd0_ff : x_ff;

   // Result register.
   assign emit_node = (ctl.op == OP_EMIT_X) ? x_ff : anc_rd0_ff;
   assign emit_ext  = EXT_W'(emit_node);

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_ancestor_in = rsp_ancestor_ff;
      if (emit) begin
         rsp_valid_in    = 1'b1;
         rsp_ancestor_in = emit_ext[NODE_FIELD_W-1:0];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         lvl_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         lvl_ff       <= lvl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      type_ff         <= type_in;
      x_ff            <= x_in;
      y_ff            <= y_in;
      up_ff           <= up_in;
      dy_ff           <= dy_in;
      rsp_ancestor_ff <= rsp_ancestor_in;
   end

   // Ancestor table: reads follow the next values of x, y and level.
   always_ff @(posedge clock) begin
      if (anc_we) begin
         anc_mem[anc_waddr] <= anc_wdata;
      end
      anc_rd0_ff <= anc_mem[{x_in, lvl_in}];
      anc_rd1_ff <= anc_mem[{y_in, lvl_in}];
   end

   // Depth store.
   always_ff @(posedge clock) begin
      if (depth_we) begin
         depth_mem[depth_waddr] <= depth_wdata;
      end
      depth_rd0_ff <= depth_mem[depth_raddr0];
      depth_rd1_ff <= depth_mem[y_ff];
   end

   // Status to the sequencer.
   assign status.is_query  = type_ff;
   assign status.node_zero = x_ff == '0;
   assign status.lvl_top   = lvl_ff == LVL_TOP;
   assign status.lvl_nz    = lvl_nz;
   assign status.nodes_eq  = x_ff == y_ff;
   assign status.clr_more  = clr_ff != CLR_LAST;
   assign status.out_busy  = out_busy;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ancestor = rsp_ancestor_ff;

   // The level counter never leaves the table.
   a_lvl_range: assert property (@(posedge clock) disable iff (reset)
      lvl_ff <= LVL_TOP)
      else $error("level counter beyond the top level");

   // The sentinel row is only ever written by the clearing sweep.
   a_sentinel: assert property (@(posedge clock) disable iff (reset)
      (anc_we && (ctl.op != OP_CLEAR)) |-> (x_ff != '0))
      else $error("add wrote the sentinel row");

   // A stored node depth is at least one.
   a_depth_nz: assert property (@(posedge clock) disable iff (reset)
      (depth_we && (ctl.op != OP_CLEAR)) |-> (depth_wdata != '0))
      else $error("node stored with depth zero");

endmodule

/* hw/rtl/lowest_common_ancestor_lifting_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowest_common_ancestor_lifting_unit: binary lifting common ancestor engine.
//
// The request channel (req_) carries one item per transfer: req_type 0 adds
// node req_node_a below parent req_node_b (parent 0 makes a root), req_type 1
// asks for the lowest common ancestor of req_node_a and req_node_b. Only a
// query returns a transfer on the result channel (rsp_ancestor).
// One item is worked at a time by a microcoded sequencer; every step issues
// at most one dependent read of the ancestor table and the depth store.
// An add writes level zero of the new row and then fills the higher levels
// before the next request is taken; an add of node 0 is dropped before
// anything is written. A query lifts the deeper node to equal depth over the
// levels and, unless the two nodes then meet, climbs both over the levels
// before it writes its result; the sequencer then returns to idle.
// After reset a clearing pass writes zero over both memories, walking every
// ancestor table address with req_ready low. A result waits in an output
// register while rsp_ready is low; the next request is still taken, and a
// later query result holds the sequencer until the register is free.
// ----------------------------------------------------------------------------
module lowest_common_ancestor_lifting_unit
   import lcal_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEFAULT,
   parameter int LEVELS    = LEVELS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_type,
   input  logic [NODE_FIELD_W-1:0] req_node_a,
   input  logic [NODE_FIELD_W-1:0] req_node_b,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [NODE_FIELD_W-1:0] rsp_ancestor
);

   localparam int NODE_W = $clog2(MAX_NODES);
   localparam int EXT_W  = (NODE_W > NODE_FIELD_W) ? NODE_W : NODE_FIELD_W;
   // A 10-bit field holds less than 256 times the smallest table size.
   localparam int MOD_STEPS = 8;

   ctl_type           ctl;
   status_type        status;
   logic [NODE_W-1:0] node_a;
   logic [NODE_W-1:0] node_b;

   // Reduce a node number modulo MAX_NODES by subtracting scaled copies.
   function automatic logic [NODE_W-1:0] node_reduce(input logic [NODE_FIELD_W-1:0] v);
      logic [EXT_W-1:0] r;
      r = EXT_W'(v);
      for (int k = MOD_STEPS - 1; k >= 0; k--) begin
         if (32'(r) >= (MAX_NODES << k)) begin
            r = r - EXT_W'(MAX_NODES << k);
         end
      end
      return r[NODE_W-1:0];
   endfunction

   assign node_a = node_reduce(req_node_a);
   assign node_b = node_reduce(req_node_b);

   // Control sequencer.
   lcal_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .ctl       (ctl),
      .req_ready (req_ready)
   );

   // Datapath with the ancestor table and depth store.
   lcal_datapath #(
      .MAX_NODES (MAX_NODES),
      .LEVELS    (LEVELS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .req_type     (req_type),
      .req_node_a   (node_a),
      .req_node_b   (node_b),
      .rsp_ready    (rsp_ready),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_ancestor (rsp_ancestor)
   );

endmodule

/* verif/lowest_common_ancestor_lifting_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowest_common_ancestor_lifting_unit_test: regression for the LCA engine.
// Builds trees by parent-first insertion and checks each common ancestor
// answer against a software copy of the lifting table and depth store.
// Covers directed corner cases, output back-pressure, and random forests
// with deep chains and broken sequences.
// ----------------------------------------------------------------------------
module lowest_common_ancestor_lifting_unit_test
   import lcal_pkg::*;
();

   localparam int MAX_NODES    = MAX_NODES_DEFAULT;
   localparam int LEVELS       = LEVELS_DEFAULT;
   localparam int MAX_NODE_ID  = MAX_NODES - 1;
   localparam int RANDOM_ITEMS = 1360;
   localparam int STALL_LIMIT  = 100000;
   localparam int SETTLE_CYCLES = 80;
   localparam int REPORT_LIMIT = 10;

   // Request kinds carried on req_type.
   localparam bit REQ_ADD   = 1'b0;
   localparam bit REQ_QUERY = 1'b1;

   typedef bit [NODE_FIELD_W-1:0] node_type;
   typedef bit [DEPTH_W-1:0]      depth_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_type;
   logic [NODE_FIELD_W-1:0] req_node_a;
   logic [NODE_FIELD_W-1:0] req_node_b;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [NODE_FIELD_W-1:0] rsp_ancestor;

   // Software copy of the block state.
   node_type  lift_table [MAX_NODES][LEVELS+1];
   depth_type node_depth [MAX_NODES];

   // Answers still owed by the block, oldest first.
   node_type  ancestor_due[$];

   int     fail_count   = 0;
   int     random_items = 0;
   int     hold_cycles  = 0;
   bit     calm_mode    = 1'b0;

   lowest_common_ancestor_lifting_unit #(
      .MAX_NODES(MAX_NODES),
      .LEVELS   (LEVELS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_type    (req_type),
      .req_node_a  (req_node_a),
      .req_node_b  (req_node_b),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_ancestor(rsp_ancestor)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Insert a node below its parent and fill its row of 2^i-step ancestors.
   function automatic void graft_node(node_type child, node_type parent);
      node_type  mid;
      depth_type pd;
      if (child == '0) return;
      pd = node_depth[parent];
      node_depth[child] = (pd >= DEPTH_MAX) ? DEPTH_MAX : pd + 1'b1;
      lift_table[child][0] = parent;
      // Levels go upward so a self-parent row reads the values just written.
      for (int lvl = 1; lvl <= LEVELS; lvl++) begin
         mid = lift_table[child][lvl-1];
         lift_table[child][lvl] = lift_table[mid][lvl-1];
      end
   endfunction

   // Lowest common ancestor by lifting to equal depth, then climbing together.
   function automatic node_type common_ancestor(node_type x, node_type y);
      node_type t;
      if (node_depth[x] < node_depth[y]) begin
         t = x;
         x = y;
         y = t;
      end
      for (int lvl = LEVELS; lvl >= 0; lvl--) begin
         if (node_depth[lift_table[x][lvl]] >= node_depth[y]) x = lift_table[x][lvl];
      end
      if (x == y) return x;
      for (int lvl = LEVELS; lvl >= 0; lvl--) begin
         if (lift_table[x][lvl] != lift_table[y][lvl]) begin
            x = lift_table[x][lvl];
            y = lift_table[y][lvl];
         end
      end
      return lift_table[x][0];
   endfunction

   // Mostly short gaps, some medium, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 20);
      return $urandom_range(21, 150);
   endfunction

   task automatic note_failure(input string what);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("ERROR at %0t: %s", $realtime, what);
   endtask

   // Offer one item and wait for its transfer; then update the prediction.
   task automatic send_item(input bit kind, input node_type a, input node_type b);
      @(negedge clock);
      req_valid  <= 1'b1;
      req_type   <= kind;
      req_node_a <= a;
      req_node_b <= b;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (kind == REQ_QUERY) ancestor_due = {ancestor_due, common_ancestor(a, b)};
      else graft_node(a, b);
   endtask

   task automatic idle_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Stop offering items until every owed answer has arrived.
   task automatic drain_results();
      idle_sender(1);
      while (ancestor_due.size() != 0) @(posedge clock);
   endtask

   // One random-phase item with an optional gap after it.
   task automatic random_item(input bit kind, input node_type a, input node_type b);
      send_item(kind, a, b);
      if (!(kind == REQ_ADD && a == '0)) random_items++;
      if (!calm_mode && $urandom_range(0, 99) < 25) idle_sender(pick_gap());
   endtask

   // Extremes of the node fields and each named corner case.
   task automatic test_directed_tree();
      send_item(REQ_QUERY, 10'd0, 10'd0);       // empty table, sentinel
      send_item(REQ_QUERY, 10'd5, 10'd7);       // nodes never added
      send_item(REQ_ADD,   10'd1, 10'd0);       // root
      send_item(REQ_ADD,   10'd1023, 10'd1);
      send_item(REQ_ADD,   10'd2, 10'd1);
      send_item(REQ_ADD,   10'd512, 10'd1023);
      send_item(REQ_QUERY, 10'd512, 10'd2);
      send_item(REQ_QUERY, 10'd1023, 10'd512);  // one node above the other
      send_item(REQ_QUERY, 10'd512, 10'd1023);
      send_item(REQ_QUERY, 10'd1, 10'd1);
      send_item(REQ_QUERY, 10'd1023, 10'd0);    // against the sentinel
      send_item(REQ_ADD,   10'd0, 10'd5);       // adding node zero is ignored
      send_item(REQ_QUERY, 10'd0, 10'd512);
      send_item(REQ_ADD,   10'd700, 10'd900);   // parent never added
      send_item(REQ_QUERY, 10'd700, 10'd1);
      send_item(REQ_ADD,   10'd1023, 10'd2);    // re-add moves the node
      send_item(REQ_QUERY, 10'd512, 10'd2);
      send_item(REQ_QUERY, 10'd1023, 10'd2);
      send_item(REQ_ADD,   10'd300, 10'd300);   // node as its own parent
      send_item(REQ_QUERY, 10'd300, 10'd1);
      send_item(REQ_QUERY, 10'd300, 10'd300);
      send_item(REQ_ADD,   10'd1022, 10'd1023);
      send_item(REQ_QUERY, 10'd1022, 10'd512);
      drain_results();
   endtask

   // The receiver holds off long enough for the block to stall its input.
   task automatic test_output_backpressure();
      node_type known [6] = '{10'd1, 10'd2, 10'd512, 10'd1023, 10'd1022, 10'd300};
      hold_cycles = 500;
      for (int k = 0; k < 12; k++) begin
         send_item(REQ_QUERY, known[$urandom_range(0, 5)], known[$urandom_range(0, 5)]);
      end
      drain_results();
   endtask

   // Random forests: mostly well-formed trees with queries on their members,
   // plus deep chains, stray parents and full-range noise items.
   task automatic test_random_forest();
      node_type grove[$];
      bit       taken [MAX_NODES];
      node_type node;
      node_type parent;
      node_type qa;
      node_type qb;
      int       grove_size;
      int       chain_pct;
      int       query_count;
      bit       first_grove;
      first_grove = 1'b1;
      while (random_items < RANDOM_ITEMS) begin
         calm_mode = ($urandom_range(0, 3) == 0);
         grove.delete();
         foreach (taken[i]) taken[i] = 1'b0;
         if (first_grove) begin
            // One deep chain so every lifting level is exercised.
            grove_size  = 600;
            chain_pct   = 95;
            first_grove = 1'b0;
         end else if ($urandom_range(0, 9) == 0) begin
            grove_size = $urandom_range(60, 150);
            chain_pct  = 70;
         end else begin
            grove_size = $urandom_range(3, 40);
            chain_pct  = $urandom_range(0, 60);
         end

         // Grow the tree parent first.
         for (int k = 0; k < grove_size; k++) begin
            do node = node_type'($urandom_range(1, MAX_NODE_ID)); while (taken[node]);
            taken[node] = 1'b1;
            if (grove.size() == 0)
               parent = ($urandom_range(0, 9) == 0) ? node_type'($urandom) : '0;
            else if ($urandom_range(0, 99) < chain_pct)
               parent = grove[$];
            else
               parent = grove[$urandom_range(0, grove.size() - 1)];
            random_item(REQ_ADD, node, parent);
            grove = {grove, node};
            if ($urandom_range(0, 19) == 0)
               random_item(REQ_QUERY, grove[$urandom_range(0, grove.size() - 1)], node);
         end

         // Queries among the members, some against outsiders.
         query_count = (grove_size / 2 + 4 > 80) ? 80 : grove_size / 2 + 4;
         for (int k = 0; k < query_count; k++) begin
            qa = grove[$urandom_range(0, grove.size() - 1)];
            qb = ($urandom_range(0, 19) == 0) ? qa : grove[$urandom_range(0, grove.size() - 1)];
            if ($urandom_range(0, 9) == 0) qb = node_type'($urandom);
            random_item(REQ_QUERY, qa, qb);
         end

         // Noise over the full field ranges.
         repeat ($urandom_range(0, 4)) begin
            random_item(1'($urandom), node_type'($urandom), node_type'($urandom));
         end

         if ($urandom_range(0, 5) == 0) drain_results();
      end
      calm_mode = 1'b0;
      drain_results();
   endtask

   // Receiver: random stalls, plus a long hold when a test asks for one.
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            stall_left  = hold_cycles;
            hold_cycles = 0;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm_mode && $urandom_range(0, 99) < 15) stall_left = pick_gap();
         end
      end
   end

   // Compare each result transfer with the oldest owed answer.
   initial begin : result_checker
      node_type want;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (ancestor_due.size() == 0) begin
               note_failure($sformatf("unexpected result, ancestor %0d", rsp_ancestor));
            end else begin
               want = ancestor_due.pop_front();
               if (rsp_ancestor !== want)
                  note_failure($sformatf("ancestor expected %0d, got %0d",
                                         want, rsp_ancestor));
            end
         end
      end
   end

   // Ends the run when no transfer happens for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_ready === 1'b1) ||
             (rsp_valid === 1'b1 && rsp_ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("lowest_common_ancestor_lifting_unit regression: fail");
      $finish;
   end

   // Main sequence.
   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_type   = REQ_ADD;
      req_node_a = '0;
      req_node_b = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_directed_tree();
      test_output_backpressure();
      test_random_forest();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && ancestor_due.size() == 0) begin
         $display("lowest_common_ancestor_lifting_unit regression: pass");
      end else begin
         $display("lowest_common_ancestor_lifting_unit regression: fail");
      end
      $finish;
   end

endmodule

/* lowest_common_ancestor_lifting_unit.f */
hw/rtl/lcal_pkg.sv
hw/rtl/lcal_sequencer.sv
hw/rtl/lcal_datapath.sv
hw/rtl/lowest_common_ancestor_lifting_unit.sv
verif/lowest_common_ancestor_lifting_unit_test.sv
